// ===== hdl/crcfr_pkg.sv =====
// Shared types, constants and the CRC-16 byte update for the framed command receiver.
package crcfr_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CRC_W   = 16;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

    localparam logic [BYTE_W-1:0] OPEN_BYTE_RST  = 8'd126;
    localparam logic [BYTE_W-1:0] CLOSE_BYTE_RST = 8'd127;
    localparam logic [BYTE_W-1:0] MAX_LEN_RST    = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OPEN_BYTE  = 2'd0,
        REG_CLOSE_BYTE = 2'd1,
        REG_MAX_LENGTH = 2'd2
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_GOOD     = 2'd0,
        ST_BAD_CRC  = 2'd1,
        ST_DROPPED  = 2'd2
    } status_t;

    typedef struct packed {
        logic [BYTE_W-1:0] open_byte;
        logic [BYTE_W-1:0] close_byte;
        logic [BYTE_W-1:0] max_length;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        status_t           status;
        logic [BYTE_W-1:0] func_code;
        logic [BYTE_W-1:0] unit_id;
        logic [BYTE_W-1:0] cmd_code;
        logic [BYTE_W-1:0] frame_length;
    } result_t;

    function automatic logic [CRC_W-1:0] crc_feed(
        input logic [CRC_W-1:0]  crc,
        input logic [BYTE_W-1:0] data
    );
        logic [CRC_W-1:0] c;
        c = crc ^ {data, {(CRC_W-BYTE_W){1'b0}}};
        for (int k = 0; k < BYTE_W; k++)
        begin
            if (c[CRC_W-1])
            begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== hdl/crcfr_cfg.sv =====
// Configuration registers: start mark, end mark and maximum frame length.
module crcfr_cfg
    import crcfr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_OPEN_BYTE:  cfg_next.open_byte  = cfg_data;
                REG_CLOSE_BYTE: cfg_next.close_byte = cfg_data;
                REG_MAX_LENGTH: cfg_next.max_length = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{open_byte: OPEN_BYTE_RST, close_byte: CLOSE_BYTE_RST,
                         max_length: MAX_LEN_RST};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/crcfr_frame.sv =====
// Frame tracker: start/end detection, running CRC, header capture and result decode.
module crcfr_frame
    import crcfr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              byte_accept,
    input  logic [BYTE_W-1:0] rx_byte,
    output result_t           result
);

    logic              in_frame_reg, in_frame_next;
    logic [BYTE_W-1:0] count_reg, count_next;
    logic [CRC_W-1:0]  crc_reg, crc_next;
    logic [BYTE_W-1:0] recent_reg [3];
    logic [BYTE_W-1:0] recent_next [3];
    logic [BYTE_W-1:0] header_reg [3];
    logic [BYTE_W-1:0] header_next [3];

    logic [BYTE_W-1:0] count_inc;
    logic [CRC_W-1:0]  crc_fed;
    logic [CRC_W-1:0]  crc_got;

    assign count_inc = count_reg + 8'd1;
    assign crc_fed   = (count_reg >= 8'd4) ? crc_feed(crc_reg, recent_reg[0]) : crc_reg;
    assign crc_got   = {recent_reg[2], recent_reg[1]};

    always_comb
    begin
        in_frame_next = in_frame_reg;
        count_next    = count_reg;
        crc_next      = crc_reg;
        recent_next   = recent_reg;
        header_next   = header_reg;
        result        = '0;
        result.status = ST_GOOD;

        if (byte_accept)
        begin
            if (!in_frame_reg)
            begin
                if (rx_byte == cfg.open_byte)
                begin
                    in_frame_next  = 1'b1;
                    count_next     = 8'd1;
                    crc_next       = '0;
                    recent_next[0] = '0;
                    recent_next[1] = '0;
                    recent_next[2] = rx_byte;
                    header_next[0] = '0;
                    header_next[1] = '0;
                    header_next[2] = '0;
                end
            end
            else
            begin
                crc_next       = crc_fed;
                recent_next[0] = recent_reg[1];
                recent_next[1] = recent_reg[2];
                recent_next[2] = rx_byte;
                count_next     = count_inc;
                unique case (count_reg)
                    8'd1:    header_next[0] = rx_byte;
                    8'd2:    header_next[1] = rx_byte;
                    8'd3:    header_next[2] = rx_byte;
                    default: header_next    = header_reg;
                endcase

                result.func_code    = header_next[0];
                result.unit_id      = header_next[1];
                result.cmd_code     = header_next[2];
                result.frame_length = count_inc;

                priority if (count_inc >= cfg.max_length)
                begin
                    result.valid  = 1'b1;
                    result.status = ST_DROPPED;
                end
                else if (rx_byte == cfg.close_byte)
                begin
                    result.valid  = 1'b1;
                    result.status = (count_inc >= 8'd3 && crc_got == crc_fed)
                                    ? ST_GOOD : ST_BAD_CRC;
                end
                else
                begin
                    result.valid = 1'b0;
                end

                if (result.valid)
                begin
                    in_frame_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            count_reg    <= '0;
            crc_reg      <= '0;
            recent_reg   <= '{default: '0};
            header_reg   <= '{default: '0};
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            count_reg    <= count_next;
            crc_reg      <= crc_next;
            recent_reg   <= recent_next;
            header_reg   <= header_next;
        end
    end

    a_close_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |=> !in_frame_reg)
        else $error("receiver still in frame after a result");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        in_frame_reg |-> count_reg != '0)
        else $error("byte count zero inside a frame");

    a_result_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (in_frame_reg && byte_accept))
        else $error("result raised outside an accepted in-frame byte");

endmodule

// ===== hdl/crcfr_out.sv =====
// Result register: holds one finished result until the downstream transfer.
module crcfr_out
    import crcfr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  result_t result,
    input  logic    out_ready,
    output logic    load_ok,
    output result_t held
);

    logic    valid_reg, valid_next;
    result_t data_reg, data_next;

    assign load_ok = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (load_ok)
        begin
            valid_next = result.valid;
            if (result.valid)
            begin
                data_next = result;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        held       = data_reg;
        held.valid = valid_reg;
    end

    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (data_reg.status == ST_GOOD || data_reg.status == ST_BAD_CRC
                       || data_reg.status == ST_DROPPED))
        else $error("held result carries an unused status code");

endmodule

// ===== hdl/crc16_framed_command_receiver.sv =====
// Top level of the CRC-16 framed command receiver.
//
//  channel  direction  handshake                 payload
//  input    in         in_valid / in_ready       rx_byte
//  output   out        out_valid / out_ready     status, func_code, unit_id,
//                                                cmd_code, frame_length
//  config   in         cfg_write                 cfg_index, cfg_data
//
// One byte per cycle while in_ready is high: the CRC update for a byte is a single unrolled
// eight-bit step, so such a byte is taken at once and its result, if any, is registered next cycle.
// in_ready drops only while a held result is not taken by out_ready.
// Reset (rst_n, asynchronous) returns to waiting for a start mark with default marks.
// Bytes that neither close nor drop a frame give no result transfer.
module crc16_framed_command_receiver
    import crcfr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [BYTE_W-1:0]    rx_byte,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           status,
    output logic [BYTE_W-1:0]    func_code,
    output logic [BYTE_W-1:0]    unit_id,
    output logic [BYTE_W-1:0]    cmd_code,
    output logic [BYTE_W-1:0]    frame_length,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data
);

    cfg_t    cfg;
    result_t result;
    result_t held;
    logic    load_ok;

    crcfr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    crcfr_frame u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .byte_accept (in_valid && load_ok),
        .rx_byte     (rx_byte),
        .result      (result)
    );

    crcfr_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .result    (result),
        .out_ready (out_ready),
        .load_ok   (load_ok),
        .held      (held)
    );

    assign in_ready     = load_ok;
    assign out_valid    = held.valid;
    assign status       = held.status;
    assign func_code    = held.func_code;
    assign unit_id      = held.unit_id;
    assign cmd_code     = held.cmd_code;
    assign frame_length = held.frame_length;

endmodule
